// ===== sv/lvf_pkg.sv =====
// Shared types, constants and coefficient tables for the vertical 8-tap luma filter.
// Depends on nothing; every other file of the block imports it.
package lvf_pkg;

    localparam int MAX_WIDTH    = 64;
    localparam int MAX_HEIGHT   = 64;
    localparam int TAPS         = 8;
    localparam int HIST         = TAPS - 1;

    localparam int SAMPLE_W     = 16;
    localparam int PIXEL_W      = 8;
    localparam int COEF_W       = 7;
    localparam int PROD_W       = SAMPLE_W + COEF_W;
    localparam int ACC_W        = PROD_W + 2;
    localparam int ROUND_OFFSET = 526336;
    localparam int OUT_SHIFT    = 12;
    localparam int PIXEL_MAX    = 255;

    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT + HIST + 1);
    localparam int CFG_W        = 7;

    localparam int FIFO_DEPTH   = 8;
    localparam int PTR_W        = $clog2(FIFO_DEPTH);
    localparam int CNT_W        = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] PHASE_QUARTER = 2'd1;
    localparam logic [1:0] PHASE_HALF    = 2'd2;
    localparam logic [1:0] PHASE_THREE_Q = 2'd3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef sample_t [HIST-1:0]         hist_t;
    typedef sample_t [TAPS-1:0]         tap_vec_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;

    // Per-item control that rides along with the sample through the pipeline.
    typedef struct packed {
        logic emit;       // item is past the first seven rows and yields a pixel
        logic block_end;  // item is the last one of the block
    } item_ctrl_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               block_end;
    } out_item_t;

    localparam coef_t COEF_QUARTER [TAPS] =
        '{-7'sd1, 7'sd4, -7'sd10, 7'sd58, 7'sd17, -7'sd5, 7'sd1, 7'sd0};
    localparam coef_t COEF_HALF [TAPS] =
        '{-7'sd1, 7'sd4, -7'sd11, 7'sd40, 7'sd40, -7'sd11, 7'sd4, -7'sd1};
    localparam coef_t COEF_THREE_Q [TAPS] =
        '{7'sd0, 7'sd1, -7'sd5, 7'sd17, 7'sd58, -7'sd10, 7'sd4, -7'sd1};

    // Tap k runs from the oldest row (0) to the newest sample (TAPS-1).
    // A phase code of zero selects the quarter set.
    function automatic coef_t tap_coef(input logic [1:0] phase, input int k);
        coef_t c;
        unique case (phase)
            PHASE_HALF:    c = COEF_HALF[k];
            PHASE_THREE_Q: c = COEF_THREE_Q[k];
            default:       c = COEF_QUARTER[k];
        endcase
        return c;
    endfunction

endpackage

// ===== sv/luma_vertical_8tap_filter_top.sv =====
// Top level of the vertical 8-tap luma interpolation filter: stream ports,
// configuration registers, row and column counters, and output credit.
// Depends on lvf_pkg, lvf_line_store, lvf_filter_dp and lvf_out_fifo.

// The block takes one 16-bit intermediate sample per clock while s_axis_tready
// is high, in raster order, block_width columns by block_height+7 rows, and from
// the eighth row on returns one 8-bit pixel per sample: the 8-tap vertical sum
// over the column with the quarter, half or three-quarter coefficient set, plus
// 526336, shifted right arithmetically by 12 and clamped to 0..255. The seven
// previous samples of each column sit in a single-port-read, single-port-write
// line store of MAX_WIDTH words of 112 bits; each sample reads its column word at
// acceptance and writes the shifted word back the next cycle, with a forwarding
// path so that a block one column wide also runs at full rate. Sustained
// throughput is one item per clock while the result side keeps up, set by the
// one read and one write of the line store per cycle. A pixel passes the store
// read at acceptance, the products, the sum and then the output queue before it
// is presented on m_axis. An eight-entry output queue with credit counting keeps
// s_axis_tready high while results wait, so input stalls only once the items in
// the pipeline and the queue together reach the queue depth. The line store is
// not cleared after reset and needs no clearing pass; a block must start with
// its first row. Register 0 is phase_select (0 acts as quarter), register 1
// block_width and register 2 block_height; out-of-range sizes are limited to
// 1..64, and they may only change while the block is idle. block_start on tuser
// restarts the row and column count; the counters also wrap on their own after
// the last sample of a block.
module luma_vertical_8tap_filter_top (
    input  logic        clk,
    input  logic        rst_n,
    // Input samples.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample (signed)
    input  logic [0:0]  s_axis_tuser,   // [0] block_start
    // Output pixels.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] pixel
    output logic        m_axis_tlast,   // block_end
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);
    import lvf_pkg::*;

    localparam logic [1:0] REG_PHASE  = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    logic [1:0]        phase_reg;
    logic [CFG_W-1:0]  width_cfg_reg;
    logic [CFG_W-1:0]  height_cfg_reg;

    logic [COL_W-1:0]  col_cnt_reg;
    logic [COL_W-1:0]  col_cnt_next;
    logic [ROW_W-1:0]  row_cnt_reg;
    logic [ROW_W-1:0]  row_cnt_next;
    logic [CNT_W-1:0]  pend_reg;
    logic [CNT_W-1:0]  pend_next;

    logic [COL_W:0]    width_eff;
    logic [COL_W-1:0]  width_m1;
    logic [ROW_W-1:0]  height_eff;
    logic [ROW_W-1:0]  last_row_idx;
    logic [COL_W-1:0]  col_cur;
    logic [ROW_W-1:0]  row_cur;
    logic [COL_W-1:0]  col_addr;
    logic              last_col;
    logic              last_row;
    logic              in_accept;
    logic              cfg_accept;
    logic [CNT_W:0]    credit_used;
    item_ctrl_t        in_ctrl;

    logic              ls_valid;
    item_ctrl_t        ls_ctrl;
    tap_vec_t          ls_taps;
    logic              dp_done;
    logic              dp_push;
    out_item_t         dp_item;
    out_item_t         head_item;
    logic [CNT_W-1:0]  fifo_count;
    logic              fifo_not_empty;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign in_accept  = s_axis_tvalid && s_axis_tready;

    // Effective block size: zero acts as one, oversize is limited.
    always_comb
    begin
        if (width_cfg_reg == '0)
        begin
            width_eff = (COL_W+1)'(1);
        end
        else if (32'(width_cfg_reg) > MAX_WIDTH)
        begin
            width_eff = (COL_W+1)'(MAX_WIDTH);
        end
        else
        begin
            width_eff = (COL_W+1)'(width_cfg_reg);
        end

        if (height_cfg_reg == '0)
        begin
            height_eff = ROW_W'(1);
        end
        else if (32'(height_cfg_reg) > MAX_HEIGHT)
        begin
            height_eff = ROW_W'(MAX_HEIGHT);
        end
        else
        begin
            height_eff = ROW_W'(height_cfg_reg);
        end
    end

    assign width_m1     = COL_W'(width_eff - 1'b1);
    assign last_row_idx = height_eff + ROW_W'(HIST);

    // A block start clears both counters before the sample is placed.
    assign col_cur  = s_axis_tuser[0] ? '0 : col_cnt_reg;
    assign row_cur  = s_axis_tuser[0] ? '0 : row_cnt_reg;
    assign last_col = (col_cur >= width_m1);
    assign last_row = (row_cur >= last_row_idx - 1'b1);
    assign col_addr = last_col ? width_m1 : col_cur;

    assign in_ctrl.emit      = (row_cur >= ROW_W'(HIST));
    assign in_ctrl.block_end = last_col && last_row;

    always_comb
    begin
        if (last_col)
        begin
            col_cnt_next = '0;
            row_cnt_next = last_row ? '0 : row_cur + 1'b1;
        end
        else
        begin
            col_cnt_next = col_cur + 1'b1;
            row_cnt_next = row_cur;
        end
    end

    // Items in the pipeline plus items queued must never exceed the queue size,
    // so every accepted item is sure of a slot when it leaves the datapath.
    always_comb
    begin
        pend_next = pend_reg;
        if (in_accept && !dp_done)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (!in_accept && dp_done)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    assign credit_used   = (CNT_W+1)'(pend_reg) + (CNT_W+1)'(fifo_count);
    assign s_axis_tready = (credit_used < (CNT_W+1)'(FIFO_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PHASE_QUARTER;
            width_cfg_reg  <= CFG_W'(MAX_WIDTH);
            height_cfg_reg <= CFG_W'(MAX_HEIGHT);
        end
        else if (cfg_accept)
        begin
            unique case (cfg_index)
                REG_PHASE:  phase_reg      <= cfg_data[1:0];
                REG_WIDTH:  width_cfg_reg  <= cfg_data;
                REG_HEIGHT: height_cfg_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            pend_reg    <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
            end
            pend_reg <= pend_next;
        end
    end

    lvf_line_store u_line_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_accept),
        .in_col    (col_addr),
        .in_sample (s_axis_tdata),
        .in_ctrl   (in_ctrl),
        .out_valid (ls_valid),
        .out_ctrl  (ls_ctrl),
        .out_taps  (ls_taps)
    );

    lvf_filter_dp u_filter_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .phase     (phase_reg),
        .in_valid  (ls_valid),
        .in_ctrl   (ls_ctrl),
        .in_taps   (ls_taps),
        .done      (dp_done),
        .push      (dp_push),
        .push_item (dp_item)
    );

    lvf_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (dp_push),
        .push_item (dp_item),
        .pop       (m_axis_tready),
        .not_empty (fifo_not_empty),
        .head_item (head_item),
        .count     (fifo_count)
    );

    assign m_axis_tvalid = fifo_not_empty;
    assign m_axis_tdata  = head_item.pixel;
    assign m_axis_tlast  = head_item.block_end;

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_used <= (CNT_W+1)'(FIFO_DEPTH))
        else $error("pipeline and queue hold more items than the queue can take");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_cnt_reg <= ROW_W'(MAX_HEIGHT + HIST - 1))
        else $error("row counter ran past the tallest block");

    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        dp_done |-> (pend_reg != '0))
        else $error("datapath finished an item that was never counted");

endmodule

// ===== sv/lvf_line_store.sv =====
// Line store of the vertical filter: one memory word of seven samples per column,
// read at accept, shifted and written back the next cycle. Depends on lvf_pkg.
module lvf_line_store (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [lvf_pkg::COL_W-1:0] in_col,
    input  lvf_pkg::sample_t       in_sample,
    input  lvf_pkg::item_ctrl_t    in_ctrl,
    output logic                   out_valid,
    output lvf_pkg::item_ctrl_t    out_ctrl,
    output lvf_pkg::tap_vec_t      out_taps
);
    import lvf_pkg::*;

    hist_t             hist_mem [MAX_WIDTH];
    hist_t             rdata_reg;
    hist_t             wr_word_reg;
    hist_t             hist_cur;
    hist_t             word_next;
    logic              s1_valid_reg;
    logic [COL_W-1:0]  s1_col_reg;
    sample_t           s1_sample_reg;
    item_ctrl_t        s1_ctrl_reg;
    logic              fwd_reg;
    logic              fwd_next;

    // The item at the write stage updates the same column that is being read
    // this cycle; the read returns the old word, so the new one is forwarded.
    assign fwd_next = in_valid && s1_valid_reg && (s1_col_reg == in_col);

    assign hist_cur = fwd_reg ? wr_word_reg : rdata_reg;

    always_comb
    begin
        for (int k = 0; k < HIST - 1; k++)
        begin
            word_next[k] = hist_cur[k+1];
        end
        word_next[HIST-1] = s1_sample_reg;
        for (int k = 0; k < HIST; k++)
        begin
            out_taps[k] = hist_cur[k];
        end
        out_taps[TAPS-1] = s1_sample_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            hist_mem[s1_col_reg] <= word_next;
        end
        if (in_valid)
        begin
            rdata_reg <= hist_mem[in_col];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            wr_word_reg <= word_next;
        end
        if (in_valid)
        begin
            s1_col_reg    <= in_col;
            s1_sample_reg <= in_sample;
            s1_ctrl_reg   <= in_ctrl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            fwd_reg      <= fwd_next;
        end
    end

    assign out_valid = s1_valid_reg;
    assign out_ctrl  = s1_ctrl_reg;

    a_fwd_needs_writer: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> $past(s1_valid_reg))
        else $error("line store forwarding without a preceding write");

endmodule

// ===== sv/lvf_filter_dp.sv =====
// Filter datapath: eight constant-coefficient products, the rounded sum, then
// shift and clamp to an 8-bit pixel. Depends on lvf_pkg.
module lvf_filter_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          phase,
    input  logic                in_valid,
    input  lvf_pkg::item_ctrl_t in_ctrl,
    input  lvf_pkg::tap_vec_t   in_taps,
    output logic                done,
    output logic                push,
    output lvf_pkg::out_item_t  push_item
);
    import lvf_pkg::*;

    prod_t       prod_reg [TAPS];
    prod_t       prod_next [TAPS];
    logic        p_valid_reg;
    item_ctrl_t  p_ctrl_reg;
    acc_t        acc_reg;
    acc_t        acc_next;
    logic        a_valid_reg;
    item_ctrl_t  a_ctrl_reg;
    logic [PIXEL_W-1:0] pixel;

    always_comb
    begin
        for (int k = 0; k < TAPS; k++)
        begin
            prod_next[k] = PROD_W'($signed(in_taps[k])) * PROD_W'(tap_coef(phase, k));
        end
    end

    always_comb
    begin
        acc_next = ACC_W'(ROUND_OFFSET);
        for (int k = 0; k < TAPS; k++)
        begin
            acc_next = acc_next + ACC_W'(prod_reg[k]);
        end
    end

    // Negative sums clamp to zero; anything above the pixel range to the maximum.
    always_comb
    begin
        if (acc_reg[ACC_W-1])
        begin
            pixel = '0;
        end
        else if (|acc_reg[ACC_W-2:OUT_SHIFT+PIXEL_W])
        begin
            pixel = PIXEL_W'(PIXEL_MAX);
        end
        else
        begin
            pixel = acc_reg[OUT_SHIFT+PIXEL_W-1:OUT_SHIFT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            prod_reg   <= prod_next;
            p_ctrl_reg <= in_ctrl;
        end
        if (p_valid_reg)
        begin
            acc_reg    <= acc_next;
            a_ctrl_reg <= p_ctrl_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= in_valid;
            a_valid_reg <= p_valid_reg;
        end
    end

    assign done                = a_valid_reg;
    assign push                = a_valid_reg && a_ctrl_reg.emit;
    assign push_item.pixel     = pixel;
    assign push_item.block_end = a_ctrl_reg.block_end;

endmodule

// ===== sv/lvf_out_fifo.sv =====
// Small output queue that decouples the filter pipeline from the result stream.
// Depends on lvf_pkg.
module lvf_out_fifo (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  lvf_pkg::out_item_t       push_item,
    input  logic                     pop,
    output logic                     not_empty,
    output lvf_pkg::out_item_t       head_item,
    output logic [lvf_pkg::CNT_W-1:0] count
);
    import lvf_pkg::*;

    out_item_t         fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign not_empty = (count_reg != '0);
    assign head_item = fifo_mem[rd_ptr_reg];
    assign count     = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !do_pop && (count_reg == CNT_W'(FIFO_DEPTH))))
        else $error("output queue written while full");

    a_empty_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 && !push) |=> (count_reg == '0))
        else $error("output queue filled without a write");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the vertical 8-tap luma filter: drives sample items
// and register writes, predicts or hand-types every pixel and compares the
// output stream. Depends on lvf_pkg and luma_vertical_8tap_filter_top.
module tb_top;
    import lvf_pkg::*;

    localparam int CLK_PERIOD       = 8;
    localparam int RESET_CYCLES     = 10;
    localparam int SETTLE_CYCLES    = 8;
    localparam int HOLD_CYCLES      = 80;
    localparam int RANDOM_ITEMS     = 1100;
    localparam int RUN_LIMIT_CYCLES = 200000;
    localparam int PRINT_LIMIT      = 200;

    // Register indexes of the configuration channel; index 3 maps to nothing.
    localparam logic [1:0] REG_PHASE  = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_NONE   = 2'd3;

    // Phase code zero is not a real position; the block treats it as quarter.
    localparam logic [1:0] PHASE_ZERO = 2'd0;

    localparam sample_t SMP_MAX  = 16'sh7FFF;
    localparam sample_t SMP_MIN  = 16'sh8000;
    localparam sample_t SMP_ZERO = 16'sh0000;

    // Coefficients indexed by phase code, oldest row first. Row zero repeats
    // the quarter set so that phase code zero needs no special handling.
    localparam int TAP_TABLE [4][TAPS] = '{
        '{-1, 4, -10, 58, 17, -5, 1, 0},
        '{-1, 4, -10, 58, 17, -5, 1, 0},
        '{-1, 4, -11, 40, 40, -11, 4, -1},
        '{0, 1, -5, 17, 58, -10, 4, -1}
    };

    typedef enum logic {STEP_WRITE, STEP_SAMPLE} step_kind_t;

    // One row of the directed plan. A write row uses the register fields, a
    // sample row the sample fields; typed rows carry a pixel known by hand.
    typedef struct {
        step_kind_t kind;
        logic [1:0] reg_index;
        logic [6:0] reg_value;
        sample_t    smp;
        logic       start;
        logic       typed;
        logic [7:0] want_pixel;
        logic       want_end;
    } directed_step_t;

    localparam int PLAN_LEN = 30;

    directed_step_t plan [PLAN_LEN] = '{
        // Phase code zero, width and height codes zero: every size acts as one,
        // so eight rows of one column give one pixel. All samples at the top
        // of the range drive the sum far above 255.
        '{STEP_WRITE,  REG_PHASE,  7'(PHASE_ZERO), SMP_ZERO, 1'b0, 1'b0, 8'd0, 1'b0},
        '{STEP_WRITE,  REG_WIDTH,  7'd0,       SMP_ZERO, 1'b0, 1'b0, 8'd0,   1'b0},
        '{STEP_WRITE,  REG_HEIGHT, 7'd0,       SMP_ZERO, 1'b0, 1'b0, 8'd0,   1'b0},
        '{STEP_SAMPLE, REG_NONE,   7'd0,       SMP_MAX,  1'b1, 1'b0, 8'd0,   1'b0},
        '{STEP_SAMPLE, REG_NONE,   7'd0,       SMP_MAX,  1'b0, 1'b0, 8'd0,   1'b0},
        '{STEP_SAMPLE, REG_NONE,   7'd0,       SMP_MAX,  1'b0, 1'b0, 8'd0,   1'b0},
        '{STEP_SAMPLE, REG_NONE,   7'd0,       SMP_MAX,  1'b0, 1'b0, 8'd0,   1'b0},
        '{STEP_SAMPLE, REG_NONE,   7'd0,       SMP_MAX,  1'b0, 1'b0, 8'd0,   1'b0},
        '{STEP_SAMPLE, REG_NONE,   7'd0,       SMP_MAX,  1'b0, 1'b0, 8'd0,   1'b0},
        '{STEP_SAMPLE, REG_NONE,   7'd0,       SMP_MAX,  1'b0, 1'b0, 8'd0,   1'b0},
        '{STEP_SAMPLE, REG_NONE,   7'd0,       SMP_MAX,  1'b0, 1'b1, 8'd255, 1'b1},
        // Half phase. The counters wrapped after the last block, so this one
        // starts without block_start. The bottom of the range clamps to zero.
        '{STEP_WRITE,  REG_PHASE,  7'(PHASE_HALF), SMP_ZERO, 1'b0, 1'b0, 8'd0, 1'b0},
        '{STEP_SAMPLE, REG_NONE,   7'd0,       SMP_MIN,  1'b0, 1'b0, 8'd0,   1'b0},
        '{STEP_SAMPLE, REG_NONE,   7'd0,       SMP_MIN,  1'b0, 1'b0, 8'd0,   1'b0},
        '{STEP_SAMPLE, REG_NONE,   7'd0,       SMP_MIN,  1'b0, 1'b0, 8'd0,   1'b0},
        '{STEP_SAMPLE, REG_NONE,   7'd0,       SMP_MIN,  1'b0, 1'b0, 8'd0,   1'b0},
        '{STEP_SAMPLE, REG_NONE,   7'd0,       SMP_MIN,  1'b0, 1'b0, 8'd0,   1'b0},
        '{STEP_SAMPLE, REG_NONE,   7'd0,       SMP_MIN,  1'b0, 1'b0, 8'd0,   1'b0},
        '{STEP_SAMPLE, REG_NONE,   7'd0,       SMP_MIN,  1'b0, 1'b0, 8'd0,   1'b0},
        '{STEP_SAMPLE, REG_NONE,   7'd0,       SMP_MIN,  1'b0, 1'b1, 8'd0,   1'b1},
        // Three-quarter phase after a write to the unused index, which must
        // change nothing. Alternating extremes toggle every sample bit.
        '{STEP_WRITE,  REG_NONE,   7'h7F,      SMP_ZERO, 1'b0, 1'b0, 8'd0,   1'b0},
        '{STEP_WRITE,  REG_PHASE,  7'(PHASE_THREE_Q), SMP_ZERO, 1'b0, 1'b0, 8'd0, 1'b0},
        '{STEP_SAMPLE, REG_NONE,   7'd0,       SMP_MIN,  1'b1, 1'b0, 8'd0,   1'b0},
        '{STEP_SAMPLE, REG_NONE,   7'd0,       SMP_MAX,  1'b0, 1'b0, 8'd0,   1'b0},
        '{STEP_SAMPLE, REG_NONE,   7'd0,       SMP_MIN,  1'b0, 1'b0, 8'd0,   1'b0},
        '{STEP_SAMPLE, REG_NONE,   7'd0,       SMP_MAX,  1'b0, 1'b0, 8'd0,   1'b0},
        '{STEP_SAMPLE, REG_NONE,   7'd0,       SMP_MIN,  1'b0, 1'b0, 8'd0,   1'b0},
        '{STEP_SAMPLE, REG_NONE,   7'd0,       SMP_MAX,  1'b0, 1'b0, 8'd0,   1'b0},
        '{STEP_SAMPLE, REG_NONE,   7'd0,       SMP_MIN,  1'b0, 1'b0, 8'd0,   1'b0},
        // The eighth row completes the block, so the counters wrap to zero.
        '{STEP_SAMPLE, REG_NONE,   7'd0,       SMP_MAX,  1'b0, 1'b0, 8'd0,   1'b0}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [15:0] sample (signed)
    logic [0:0]  s_axis_tuser;   // [0] block_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] pixel
    logic        m_axis_tlast;   // block_end
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_data;

    // Hand-typed expectation that travels beside the item on the input bus.
    logic        drv_typed;
    out_item_t   drv_want;

    // Predictor state: register copies, counters and the per-column history.
    logic [1:0]  cfg_phase  = PHASE_QUARTER;
    logic [6:0]  cfg_width  = 7'd64;
    logic [6:0]  cfg_height = 7'd64;
    int          col_cnt    = 0;
    int          row_cnt    = 0;
    sample_t     line_hist [MAX_WIDTH][HIST];

    out_item_t   pending_pixels [$];
    int          items_sent  = 0;
    int          error_count = 0;
    bit          held_once   = 1'b0;
    bit          paused_once = 1'b0;
    logic        calm;

    // A stretch of the run in which send_sample adds no random gaps and the result side keeps tready high.
    assign calm = (items_sent >= 600) && (items_sent < 800);

    luma_vertical_8tap_filter_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Size codes out of range are limited: zero acts as one, and anything
    // above the maximum acts as the maximum.
    function automatic int eff_size(input logic [6:0] code, input int limit);
        if (code == 7'd0)
            return 1;
        if (int'(code) > limit)
            return limit;
        return int'(code);
    endfunction

    // Steps the predictor by one accepted sample. The sample meets the seven
    // stored samples of its column; from the eighth row on that gives a pixel.
    task automatic filter_column(input sample_t smp, input logic start,
                                 output logic emits, output out_item_t pixel_out);
        int   w;
        int   h;
        int   col;
        int   acc;
        int   px;
        logic last_col;
        logic last_row;
        w = eff_size(cfg_width, MAX_WIDTH);
        h = eff_size(cfg_height, MAX_HEIGHT);
        if (start)
        begin
            col_cnt = 0;
            row_cnt = 0;
        end
        // A column count left beyond a narrowed width uses the last column.
        col      = (col_cnt >= w) ? w - 1 : col_cnt;
        last_col = (col_cnt >= w - 1);
        last_row = (row_cnt >= h + HIST - 1);
        emits    = (row_cnt >= HIST);
        pixel_out = '0;
        if (emits)
        begin
            acc = ROUND_OFFSET;
            for (int k = 0; k < HIST; k++)
                acc += TAP_TABLE[cfg_phase][k] * int'(line_hist[col][k]);
            acc += TAP_TABLE[cfg_phase][HIST] * int'(smp);
            if (acc < 0)
                px = 0;
            else
            begin
                px = acc >>> OUT_SHIFT;
                if (px > PIXEL_MAX)
                    px = PIXEL_MAX;
            end
            pixel_out.pixel     = px[7:0];
            pixel_out.block_end = last_col && last_row;
        end
        for (int k = 0; k < HIST - 1; k++)
            line_hist[col][k] = line_hist[col][k + 1];
        line_hist[col][HIST - 1] = smp;
        if (last_col)
        begin
            col_cnt = 0;
            row_cnt = last_row ? 0 : row_cnt + 1;
        end
        else
            col_cnt++;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < PRINT_LIMIT)
            $display("mismatch at %0t: %s, got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // All checking happens here at the rising edge. Results are checked before
    // the item accepted at the same edge is predicted, so the order is fixed.
    always @(posedge clk)
    begin : scoreboard
        logic      emits;
        out_item_t predicted;
        out_item_t oldest;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_pixels.size() == 0)
                    report_mismatch("pixel with nothing pending", m_axis_tdata, -1);
                else
                begin
                    oldest = pending_pixels.pop_front();
                    if (m_axis_tdata !== oldest.pixel)
                        report_mismatch("pixel", m_axis_tdata, oldest.pixel);
                    if (m_axis_tlast !== oldest.block_end)
                        report_mismatch("block_end", m_axis_tlast, oldest.block_end);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                filter_column(sample_t'(s_axis_tdata), s_axis_tuser[0], emits, predicted);
                if (drv_typed)
                    pending_pixels.push_back(drv_want);
                else if (emits)
                    pending_pixels.push_back(predicted);
                items_sent++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PHASE:  cfg_phase  = cfg_data[1:0];
                    REG_WIDTH:  cfg_width  = cfg_data;
                    REG_HEIGHT: cfg_height = cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    // Intermediate samples mostly look like real ones: a pixel scaled by 64
    // less 8192, with some noise. The rest spans the whole 16-bit range.
    function automatic sample_t next_sample();
        int pick;
        int v;
        pick = $urandom_range(0, 9);
        if (pick < 7)
        begin
            v = int'($urandom_range(0, 255)) * 64 - 8192 + int'($urandom_range(0, 63)) - 32;
            return sample_t'(v);
        end
        if (pick == 7)
            return ($urandom_range(0, 1) != 0) ? SMP_MAX : SMP_MIN;
        return sample_t'($urandom);
    endfunction

    // Stimulus tasks are entered and left at a falling edge.
    task automatic send_sample(input sample_t smp, input logic start,
                               input logic typed, input out_item_t want);
        while (!calm && ($urandom_range(0, 99) < 13))
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= start;
        drv_typed     <= typed;
        drv_want      <= want;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // The caller lowers cfg_valid once its last write is done.
    task automatic write_reg(input logic [1:0] index, input logic [6:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stops sending and waits until every predicted pixel has come out. The
    // extra cycles cover items of the first rows still inside the pipeline.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Sends one block until the predicted counters wrap. Small blocks may be
    // restarted by block_start in the middle, or have a register changed while
    // the block is idle halfway through. The width is only ever narrowed there,
    // so no column is read before this block has written it.
    task automatic send_block(input logic lead_start, input logic small_block);
        int   n;
        int   tweak_at;
        logic start;
        n = 0;
        tweak_at = (small_block && $urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : -1;
        do
        begin
            if (n == tweak_at)
            begin
                drain_results();
                case ($urandom_range(0, 2))
                    0: write_reg(REG_PHASE, 7'($urandom_range(0, 3)));
                    1: write_reg(REG_WIDTH,
                                 7'($urandom_range(1, eff_size(cfg_width, MAX_WIDTH))));
                    default: write_reg(REG_HEIGHT, 7'($urandom_range(0, 12)));
                endcase
                cfg_valid <= 1'b0;
            end
            // Now and then the sender pauses until every pixel has come out.
            if (pending_pixels.size() > 0 &&
                ((!paused_once && items_sent >= 750) || $urandom_range(0, 149) == 0))
            begin
                paused_once = 1'b1;
                drain_results();
            end
            start = (n == 0) ? lead_start : (small_block && $urandom_range(0, 199) == 0);
            send_sample(next_sample(), start, 1'b0, '0);
            n++;
        end
        while (col_cnt != 0 || row_cnt != 0);
    endtask

    // Main stimulus: reset, the directed plan, then random settings.
    initial
    begin : stimulus
        int         random_goal;
        int         setting_no;
        int         blocks;
        int         pick;
        logic [1:0] ph;
        logic [6:0] w;
        logic [6:0] h;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_PHASE;
        cfg_data      = '0;
        drv_typed     = 1'b0;
        drv_want      = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed plan. Registers are written only once the block has drained.
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (plan[i].kind == STEP_WRITE)
            begin
                if (i == 0 || plan[i - 1].kind == STEP_SAMPLE)
                    drain_results();
                write_reg(plan[i].reg_index, plan[i].reg_value);
            end
            else
            begin
                cfg_valid <= 1'b0;
                send_sample(plan[i].smp, plan[i].start, plan[i].typed,
                            '{pixel: plan[i].want_pixel, block_end: plan[i].want_end});
            end
        end

        // Random settings. The first three are the extremes: a full-width block
        // of one output row, and two one-column blocks of full height with the
        // height code in range and beyond it. Later ones keep blocks small.
        random_goal = items_sent + RANDOM_ITEMS;
        setting_no  = 0;
        while (items_sent < random_goal)
        begin
            ph = 2'($urandom_range(0, 3));
            case (setting_no)
                0:
                begin
                    w = ($urandom_range(0, 1) != 0) ? 7'd64 : 7'($urandom_range(65, 127));
                    h = 7'd0;
                end
                1:
                begin
                    w = 7'd1;
                    h = 7'd64;
                end
                2:
                begin
                    w = 7'd0;
                    h = 7'($urandom_range(65, 127));
                end
                default:
                begin
                    w = ($urandom_range(0, 19) == 0) ? 7'd0 : 7'($urandom_range(1, 8));
                    pick = $urandom_range(0, 19);
                    if (pick < 2)
                        h = 7'd0;
                    else if (pick == 2)
                    begin
                        // Full height only with a narrow block.
                        h = 7'($urandom_range(64, 127));
                        if (w > 7'd2)
                            w = 7'($urandom_range(0, 2));
                    end
                    else
                        h = 7'($urandom_range(1, 8));
                end
            endcase
            // The counters are at zero here, so the width may also grow.
            drain_results();
            write_reg(REG_PHASE, 7'(ph));
            write_reg(REG_WIDTH, w);
            write_reg(REG_HEIGHT, h);
            cfg_valid <= 1'b0;
            blocks = (setting_no < 3) ? 1 : $urandom_range(1, 3);
            repeat (blocks)
                send_block($urandom_range(0, 99) < 85,
                           eff_size(cfg_width, MAX_WIDTH) *
                           (eff_size(cfg_height, MAX_HEIGHT) + HIST) <= 150);
            setting_no++;
        end

        drain_results();
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Result side. Besides random idling it holds off once for a long stretch
    // while pixels are pending, so the output queue fills and the input stalls.
    initial
    begin : result_sink
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (!held_once && items_sent >= 200 && pending_pixels.size() > 0)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= calm || ($urandom_range(0, 99) >= 13);
        end
    end

    // Watchdog for a run that hangs on a handshake or a missing pixel.
    initial
    begin : watchdog
        #(CLK_PERIOD * RUN_LIMIT_CYCLES);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/lvf_pkg.sv
sv/lvf_line_store.sv
sv/lvf_filter_dp.sv
sv/lvf_out_fifo.sv
sv/luma_vertical_8tap_filter_top.sv
bench/tb_top.sv
